@@ src/rpc_pkg.sv @@
// ---------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants for the relation property checker: row width,
// size register layout, controller states and controller/datapath bundles.
// ---------------------------------------------------------------------------
package rpc_pkg;

   // Width of one matrix row on the request channel
   localparam int ROW_W = 16;

   // Size register layout and reset value
   localparam int              SIZE_W     = 5;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   // Default capacity of the row store
   localparam int MAX_ELEMENTS_DEFAULT = 16;

   // Controller states
   typedef enum logic {
      ST_LOAD,
      ST_EVAL
   } rpc_state_type;

   // Property flags, one bit each
   typedef struct packed {
      logic reflexive;
      logic antireflexive;
      logic symmetric;
      logic antisymmetric;
      logic asymmetric;
      logic transitive;
      logic antitransitive;
      logic complete;
   } rpc_flags_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_row;   // store the accepted row and advance the row counter
      logic clear;      // start a property pass: index to zero, flags to one
      logic step;       // evaluate the current row and advance the index
      logic emit;       // load the result register with the final flags
   } rpc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_row;   // row counter points at row n-1
      logic last_eval;  // evaluation index points at row n-1
   } rpc_status_type;

endpackage

@@ src/rpc_if.sv @@
// ---------------------------------------------------------------------------
// rpc_if
// Valid/ready channels of the relation property checker: one for matrix
// rows and one for property results.
// ---------------------------------------------------------------------------
interface rpc_req_if
   import rpc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_bits;

   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

interface rpc_rsp_if;
   logic valid;
   logic ready;
   logic reflexive;
   logic antireflexive;
   logic symmetric;
   logic antisymmetric;
   logic asymmetric;
   logic transitive;
   logic antitransitive;
   logic complete;

   modport source (
      output valid, input ready,
      output reflexive, output antireflexive, output symmetric, output antisymmetric,
      output asymmetric, output transitive, output antitransitive, output complete
   );
   modport sink (
      input valid, output ready,
      input reflexive, input antireflexive, input symmetric, input antisymmetric,
      input asymmetric, input transitive, input antitransitive, input complete
   );
endinterface

@@ src/rpc_datapath.sv @@
// ---------------------------------------------------------------------------
// rpc_datapath
// Size register, row store, row counter and the shared per-row property
// unit with its flag accumulators and the result register.
// ---------------------------------------------------------------------------
module rpc_datapath
   import rpc_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [SIZE_W-1:0]   csr_write_data,
   input  logic [ROW_W-1:0]    row_bits,
   input  rpc_cmd_type         cmd,
   output rpc_status_type      status,
   output rpc_flags_type       result
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int VW = (MAX_ELEMENTS > ROW_W) ? MAX_ELEMENTS : ROW_W;

   logic [SIZE_W-1:0] size_ff;
   logic [NW-1:0]     n;
   logic [AW-1:0]     last_idx;
   logic [ROW_W-1:0]  col_mask;
   logic [ROW_W-1:0]  store_ff [MAX_ELEMENTS];
   logic [AW-1:0]     row_cnt_ff, row_cnt_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [VW-1:0]     row_cur, col_cur, comp, up_mask;
   logic              diag;
   rpc_flags_type     row_ok, acc_ff, acc_in, acc_next, result_ff;

   // Hold the size register; a write restarts loading
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   // Clamp the size into 1..MAX_ELEMENTS
   always_comb begin
      if (size_ff == '0) begin
         n = NW'(1);
      end else if (int'(size_ff) > MAX_ELEMENTS) begin
         n = NW'(MAX_ELEMENTS);
      end else begin
         n = NW'(size_ff);
      end
      last_idx = AW'(n - NW'(1));
      for (int j = 0; j < ROW_W; j++) begin
         col_mask[j] = (j < int'(n));
      end
   end

   // Advance the row counter on each stored row
   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (csr_write_enable) begin
         row_cnt_in = '0;
      end else if (cmd.load_row) begin
         row_cnt_in = status.last_row ? '0 : row_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Write the masked row into the store
   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         store_ff[row_cnt_ff] <= row_bits & col_mask;
      end
   end

   // Read the current row, its column and the composition row
   always_comb begin
      logic [VW-1:0] wide;
      row_cur = VW'(store_ff[idx_ff]);
      col_cur = '0;
      comp    = '0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         wide       = VW'(store_ff[k]);
         col_cur[k] = wide[idx_ff];
         if (row_cur[k]) begin
            comp = comp | wide;
         end
      end
      for (int j = 0; j < VW; j++) begin
         up_mask[j] = (j > int'(idx_ff)) && (j < int'(n));
      end
      diag = row_cur[idx_ff];
   end

   // Check this row's share of each property
   always_comb begin
      row_ok.reflexive      = diag;
      row_ok.antireflexive  = !diag;
      row_ok.symmetric      = ~|((row_cur ^ col_cur) & up_mask);
      row_ok.antisymmetric  = ~|(row_cur & col_cur & up_mask);
      row_ok.asymmetric     = row_ok.antisymmetric && !diag;
      row_ok.transitive     = ~|(comp & ~row_cur);
      row_ok.antitransitive = ~|(comp & row_cur);
      row_ok.complete       = ~|(~(row_cur | col_cur) & up_mask);
      acc_next              = acc_ff & row_ok;
   end

   // Accumulate flags and advance the evaluation index
   always_comb begin
      acc_in = acc_ff;
      idx_in = idx_ff;
      if (cmd.clear) begin
         acc_in = '1;
         idx_in = '0;
      end else if (cmd.step) begin
         acc_in = acc_next;
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      idx_ff <= idx_in;
      if (cmd.emit) begin
         result_ff <= acc_next;
      end
   end

   assign status.last_row  = (row_cnt_ff == last_idx);
   assign status.last_eval = (idx_ff == last_idx);
   assign result           = result_ff;

   // A diagonal entry is either set or clear, so no result is both
   a_refl_excl: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.emit) |-> !(result_ff.reflexive && result_ff.antireflexive))
      else $error("result both reflexive and antireflexive");

   // Asymmetry needs antisymmetry and antireflexivity
   a_asym_imp: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.emit) |-> (!result_ff.asymmetric ||
                           (result_ff.antisymmetric && result_ff.antireflexive)))
      else $error("asymmetric flag inconsistent");

   // The row counter stays inside the active size
   a_row_cnt: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (row_cnt_ff <= last_idx))
      else $error("row counter beyond active size");

endmodule

@@ src/rpc_controller.sv @@
// ---------------------------------------------------------------------------
// rpc_controller
// Load/evaluate sequencer: takes rows, runs the property pass once the last
// row is in, and hands the result to the output register.
// ---------------------------------------------------------------------------
module rpc_controller
   import rpc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  rpc_status_type status,
   output rpc_cmd_type    cmd
);

   rpc_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && status.last_row) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.last_eval && slot_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready    = 1'b1;
            cmd.load_row = req_valid;
            cmd.clear    = req_valid && status.last_row;
         end
         ST_EVAL: begin
            cmd.step = !status.last_eval || slot_free;
            cmd.emit = status.last_eval && slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A result appears only at the end of a property pass
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EVAL))
      else $error("result raised outside a property pass");

   // A waiting result is never overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("result overwritten while waiting");

endmodule

@@ src/relation_property_checker_top.sv @@
// ---------------------------------------------------------------------------
// relation_property_checker_top
// Checks eight properties of a boolean relation loaded row by row.
// ---------------------------------------------------------------------------
// Rows are taken one per cycle while loading; row i arrives as a bit vector
// with bit j set when element i relates to element j, and columns at or
// above the active size n (csr register, 0 read as 1, clamped to
// MAX_ELEMENTS) are masked. A csr write restarts loading. After the n-th row
// the block runs a property pass, one stored row per cycle through a single
// evaluation unit (diagonal, column compare and one composition row), with
// the last row waiting for a free output register, and takes no rows during
// it. The result waits in an output register while the next relation loads.
// ---------------------------------------------------------------------------
module relation_property_checker_top
   import rpc_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [SIZE_W-1:0] csr_write_data,
   rpc_req_if.sink           req_if,
   rpc_rsp_if.source         rsp_if
);

   rpc_cmd_type    cmd;
   rpc_status_type status;
   rpc_flags_type  result;

   rpc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpc_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .row_bits         (req_if.row_bits),
      .cmd              (cmd),
      .status           (status),
      .result           (result)
   );

   // Drive the result payload
   assign rsp_if.reflexive      = result.reflexive;
   assign rsp_if.antireflexive  = result.antireflexive;
   assign rsp_if.symmetric      = result.symmetric;
   assign rsp_if.antisymmetric  = result.antisymmetric;
   assign rsp_if.asymmetric     = result.asymmetric;
   assign rsp_if.transitive     = result.transitive;
   assign rsp_if.antitransitive = result.antitransitive;
   assign rsp_if.complete       = result.complete;

endmodule

@@ tb/sv/relation_property_checker_top_tb.sv @@
// ---------------------------------------------------------------------------
// relation_property_checker_top_tb
// Self-checking bench for the relation property checker. Relations of many
// shapes (orders, equivalences, tournaments, bipartite, noise) are loaded row
// by row under several size settings, and every flag result is compared with
// a local predictor that tracks the row store, the row count and the size.
// ---------------------------------------------------------------------------
module relation_property_checker_top_tb
   import rpc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ELEMENTS         = MAX_ELEMENTS_DEFAULT;
   localparam int SETTLE_CYCLES    = 2 * ELEMENTS + 8;
   localparam int STALL_LIMIT      = 5000;
   localparam int MISMATCH_REPORTS = 10;

   // Shapes of generated relations
   typedef enum int {
      SHAPE_NOISE,
      SHAPE_SPARSE,
      SHAPE_SYMMETRIC,
      SHAPE_EQUIV,
      SHAPE_PREORDER,
      SHAPE_STRICT_ORDER,
      SHAPE_TOURNAMENT,
      SHAPE_BIPARTITE,
      SHAPE_EMPTY,
      SHAPE_FULL
   } shape_kind_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [SIZE_W-1:0] csr_write_data;

   rpc_req_if req_if ();
   rpc_rsp_if rsp_if ();

   relation_property_checker_top #(
      .MAX_ELEMENTS(ELEMENTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_if          (req_if),
      .rsp_if          (rsp_if)
   );

   // Predictor state: stored rows, rows of the current relation, size setting
   logic [ROW_W-1:0]  held_rows [ELEMENTS];
   int                rows_held;
   logic [SIZE_W-1:0] size_setting;
   rpc_flags_type     flag_queue [$];

   // Stimulus state
   logic [ROW_W-1:0]  stim_rows [ELEMENTS];
   int                sender_idle_pct;
   int                receiver_idle_pct;
   int                rows_accepted;
   int                failures;
   int                stall_cycles;

   string flag_names [8] = '{"reflexive", "antireflexive", "symmetric", "antisymmetric",
                             "asymmetric", "transitive", "antitransitive", "complete"};

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int active_size(input logic [SIZE_W-1:0] setting);
      if (setting == '0) return 1;
      if (setting > ELEMENTS) return ELEMENTS;
      return int'(setting);
   endfunction

   function automatic logic [ROW_W-1:0] column_mask(input int n);
      logic [ROW_W:0] wide;
      wide    = '0;
      wide[n] = 1'b1;
      wide    = wide - 1'b1;
      return wide[ROW_W-1:0];
   endfunction

   // Evaluate the eight properties over rows 0..n-1 of the held relation
   function automatic rpc_flags_type relation_flags(input int n);
      rpc_flags_type    flags;
      logic             refl, arefl, sym, antisym, trans, atrans, compl;
      logic [ROW_W-1:0] composed;
      refl = 1'b1; arefl = 1'b1; sym = 1'b1; antisym = 1'b1;
      trans = 1'b1; atrans = 1'b1; compl = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (held_rows[i][i]) arefl = 1'b0;
         else refl = 1'b0;
         for (int j = i + 1; j < n; j++) begin
            if (held_rows[i][j] != held_rows[j][i]) sym = 1'b0;
            if (held_rows[i][j] && held_rows[j][i]) antisym = 1'b0;
            if (!held_rows[i][j] && !held_rows[j][i]) compl = 1'b0;
         end
         composed = '0;
         for (int k = 0; k < n; k++)
            if (held_rows[i][k]) composed |= held_rows[k];
         if ((composed & ~held_rows[i]) != '0) trans = 1'b0;
         if ((composed & held_rows[i]) != '0) atrans = 1'b0;
      end
      flags.reflexive      = refl;
      flags.antireflexive  = arefl;
      flags.symmetric      = sym;
      flags.antisymmetric  = antisym;
      flags.asymmetric     = antisym & arefl;
      flags.transitive     = trans;
      flags.antitransitive = atrans;
      flags.complete       = compl;
      return flags;
   endfunction

   // Store an accepted row; queue the flags once the relation is complete
   function automatic void predict_row(input logic [ROW_W-1:0] row);
      int n;
      n = active_size(size_setting);
      if (rows_held >= n) rows_held = 0;
      held_rows[rows_held] = row & column_mask(n);
      rows_held++;
      if (rows_held == n) begin
         rows_held = 0;
         flag_queue.push_back(relation_flags(n));
      end
   endfunction

   function automatic void note_failure(input string text);
      failures++;
      if (failures <= MISMATCH_REPORTS) $display("%s", text);
   endfunction

   // Receiver: stall at random per the current idle rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Compare each accepted result with the oldest expected flags
   always @(posedge clock) begin
      rpc_flags_type seen;
      rpc_flags_type wanted;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = {rsp_if.reflexive, rsp_if.antireflexive, rsp_if.symmetric,
                 rsp_if.antisymmetric, rsp_if.asymmetric, rsp_if.transitive,
                 rsp_if.antitransitive, rsp_if.complete};
         if (flag_queue.size() == 0) begin
            note_failure($sformatf("unexpected result, flags %b", seen));
         end else begin
            wanted = flag_queue.pop_front();
            for (int f = 0; f < 8; f++)
               if (seen[7-f] !== wanted[7-f])
                  note_failure($sformatf("%s mismatch: expected %b, got %b",
                                         flag_names[f], wanted[7-f], seen[7-f]));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Send one row; valid stays high after acceptance for back-to-back items
   task automatic send_row(input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid    <= 1'b0;
         req_if.row_bits <= ROW_W'($urandom);
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.row_bits <= row;
      do @(posedge clock); while (!req_if.ready);
      predict_row(row);
      rows_accepted++;
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (flag_queue.size() != 0) @(posedge clock);
   endtask

   // Write the size register once the block has gone quiet
   task automatic write_size(input logic [SIZE_W-1:0] setting);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      size_setting = setting;
      rows_held    = 0;
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return '0;
      if (roll < 8) return SIZE_W'(1);
      if (roll < 12) return SIZE_W'(ELEMENTS);
      if (roll < 14) return '1;
      if (roll < 16) return SIZE_W'($urandom_range(ELEMENTS + 1, 30));
      if (roll < 75) return SIZE_W'($urandom_range(2, 6));
      return SIZE_W'($urandom_range(7, ELEMENTS));
   endfunction

   // Build one relation of a random shape into stim_rows, junk in columns n and up
   function automatic void make_relation(input int n);
      shape_kind_type   shape;
      logic [ROW_W-1:0] mask;
      int               label [ELEMENTS];
      int               i, j, k;
      mask  = column_mask(n);
      shape = shape_kind_type'($urandom_range(0, SHAPE_FULL));
      for (i = 0; i < ELEMENTS; i++) begin
         stim_rows[i] = '0;
         label[i]     = $urandom_range(0, 3);
      end
      case (shape)
         SHAPE_NOISE: begin
            for (i = 0; i < n; i++) stim_rows[i] = ROW_W'($urandom);
         end
         SHAPE_SPARSE: begin
            for (i = 0; i < n; i++)
               stim_rows[i] = ROW_W'($urandom & $urandom & $urandom);
         end
         SHAPE_SYMMETRIC: begin
            for (i = 0; i < n; i++)
               for (j = i; j < n; j++) begin
                  stim_rows[i][j] = 1'($urandom_range(1));
                  stim_rows[j][i] = stim_rows[i][j];
               end
         end
         SHAPE_EQUIV: begin
            for (i = 0; i < n; i++)
               for (j = 0; j < n; j++) stim_rows[i][j] = (label[i] == label[j]);
         end
         SHAPE_PREORDER, SHAPE_STRICT_ORDER: begin
            for (i = 0; i < n; i++)
               for (j = 0; j < n; j++)
                  if (shape == SHAPE_PREORDER) stim_rows[i][j] = (i == j) ||
                     ($urandom_range(5) == 0);
                  else stim_rows[i][j] = (j > i) && ($urandom_range(3) == 0);
            // close under composition
            for (k = 0; k < n; k++)
               for (i = 0; i < n; i++)
                  if (stim_rows[i][k]) stim_rows[i] |= stim_rows[k];
         end
         SHAPE_TOURNAMENT: begin
            for (i = 0; i < n; i++)
               for (j = i + 1; j < n; j++)
                  if ($urandom_range(1)) stim_rows[i][j] = 1'b1;
                  else stim_rows[j][i] = 1'b1;
         end
         SHAPE_BIPARTITE: begin
            for (i = 0; i < n; i++)
               for (j = 0; j < n; j++)
                  stim_rows[i][j] = label[i][0] && !label[j][0] && $urandom_range(1);
         end
         SHAPE_FULL: begin
            for (i = 0; i < n; i++) stim_rows[i] = '1;
         end
         default: ;
      endcase
      // flip one entry now and then for near misses
      if (shape != SHAPE_NOISE && $urandom_range(3) == 0) begin
         i = $urandom_range(n - 1);
         j = $urandom_range(n - 1);
         stim_rows[i][j] = ~stim_rows[i][j];
      end
      for (i = 0; i < n; i++)
         stim_rows[i] = (stim_rows[i] & mask) | (ROW_W'($urandom) & ~mask);
   endfunction

   // Size at reset: full relation over all elements
   task automatic test_reset_size();
      for (int i = 0; i < active_size(SIZE_RESET); i++) send_row('1);
      drain_results();
   endtask

   // One element: columns above zero are masked
   task automatic test_size_one();
      write_size(SIZE_W'(1));
      send_row(16'hFFFE);
      send_row(16'hFFFF);
   endtask

   // Size zero reads as one element
   task automatic test_size_zero();
      write_size('0);
      send_row(16'h8001);
   endtask

   // A size write drops a partly loaded relation
   task automatic test_reload_discard();
      write_size(SIZE_W'(3));
      send_row(16'h0006);
      send_row(16'h0001);
      write_size(SIZE_W'(2));
      send_row(16'h0002);
      send_row(16'h0001);
   endtask

   // Random relations under changing sizes, some abandoned part way
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int budget);
      int target, n, relations, cut;
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      target            = rows_accepted + budget;
      while (rows_accepted < target) begin
         write_size(pick_size());
         n         = active_size(size_setting);
         relations = $urandom_range(2, 8);
         for (int r = 0; r < relations; r++) begin
            make_relation(n);
            cut = n;
            if (n > 1 && $urandom_range(11) == 0) cut = $urandom_range(1, n - 1);
            for (int i = 0; i < cut; i++) send_row(stim_rows[i]);
            if (cut < n) break;
            if ($urandom_range(15) == 0) drain_results();
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_if.valid     <= 1'b0;
      req_if.row_bits  <= '0;
      size_setting      = SIZE_RESET;
      rows_held         = 0;
      rows_accepted     = 0;
      failures          = 0;
      sender_idle_pct   = 34;
      receiver_idle_pct = 67;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_size_one();
      test_size_zero();
      test_reload_discard();
      test_random_traffic(34, 67, 600);
      test_random_traffic(67, 34, 600);
      test_random_traffic(0, 0, 600);

      // wind down and look for leftovers
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (flag_queue.size() != 0)
         note_failure($sformatf("%0d results never arrived", flag_queue.size()));
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/rpc_pkg.sv
src/rpc_if.sv
src/rpc_datapath.sv
src/rpc_controller.sv
src/relation_property_checker_top.sv
tb/sv/relation_property_checker_top_tb.sv
